>>> sv/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Depends on nothing; the including module supplies clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, ignored while reset is asserted.
`define TEB_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Implication checked on every rising clock edge, ignored while reset is asserted.
`define TEB_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> sv/teb_pkg.sv
// Types and constants of the TIM element builder.
// Used by teb_cfg, the core and the checker; depends on nothing.
`default_nettype none

package teb_pkg;

	// Operation codes of an input beat.
	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_QUERY = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	// Configuration register indexes and the APB address width.
	localparam int unsigned CFG_AW = 4;
	localparam logic [1:0] REG_DTIM_COUNT  = 2'd0;
	localparam logic [1:0] REG_DTIM_PERIOD = 2'd1;
	localparam logic [1:0] REG_MCAST       = 2'd2;

	// Information field byte positions ahead of the bitmap octets.
	localparam logic [7:0] BYTE_DTIM_COUNT  = 8'd0;
	localparam logic [7:0] BYTE_DTIM_PERIOD = 8'd1;
	localparam logic [7:0] BYTE_BMAP_CTRL   = 8'd2;
	localparam logic [7:0] BYTE_FIRST_OCTET = 8'd3;

	typedef struct packed {
		logic [1:0]  op;
		logic [10:0] aid;
		logic [7:0]  byte_index;
	} teb_in_t;

	typedef struct packed {
		logic        present;
		logic [7:0]  element_byte;
		logic        last_byte;
		logic [7:0]  info_length;
		logic        error;
	} teb_out_t;

	typedef struct packed {
		logic [7:0] dtim_count;
		logic [7:0] dtim_period;
		logic       multicast_pending;
	} teb_cfg_t;

endpackage

`default_nettype wire

>>> sv/teb_ram.sv
// Generic simple dual-port RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module teb_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 251,
	parameter int unsigned AW    = 8
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port; read data holds when not read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> sv/teb_cfg.sv
// APB configuration registers of the TIM element builder.
// Depends on teb_pkg.
`default_nettype none

module teb_cfg
	import teb_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [CFG_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	output teb_cfg_t               cfg
);

	logic [7:0] dtim_count_q;
	logic [7:0] dtim_period_q;
	logic       mcast_q;
	logic [1:0] reg_idx;
	logic       wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;

	// Register writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dtim_count_q  <= 8'd0;
			dtim_period_q <= 8'd1;
			mcast_q       <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_DTIM_COUNT:  dtim_count_q  <= pwdata[7:0];
				REG_DTIM_PERIOD: dtim_period_q <= pwdata[7:0];
				REG_MCAST:       mcast_q       <= pwdata[0];
				default:         ;
			endcase
		end
	end

	// Read-back mux.
	always_comb begin
		unique case (reg_idx)
			REG_DTIM_COUNT:  prdata = {24'd0, dtim_count_q};
			REG_DTIM_PERIOD: prdata = {24'd0, dtim_period_q};
			REG_MCAST:       prdata = {31'd0, mcast_q};
			default:         prdata = 32'd0;
		endcase
	end

	assign cfg = '{dtim_count: dtim_count_q, dtim_period: dtim_period_q,
		multicast_pending: mcast_q};

endmodule

`default_nettype wire

>>> sv/tim_element_builder_core.sv
// An accepted input beat is captured alongside the bitmap memory read; in the execute
// state, once the read has returned, it writes the octet back and loads its result into
// the output register, where it waits for as long as the output stalls. The execute state
// is left once the output register is free; no new item is taken until then. No clearing pass after reset:
// per-octet valid bits in flip-flops are cleared by arst_n and by a clear item.
`default_nettype none

module tim_element_builder_core
	import teb_pkg::*;
#(
	parameter int unsigned MAX_AID = 2007
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire teb_in_t           in_data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output teb_out_t               out_data,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [CFG_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready
);

	localparam int unsigned NUM_OCTETS = MAX_AID / 8 + 1;
	localparam int unsigned AW = (NUM_OCTETS > 1) ? $clog2(NUM_OCTETS) : 1;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	teb_cfg_t cfg;

	logic                  state_q;
	logic [NUM_OCTETS-1:0] valid_q;
	logic [10:0]           low_q;
	logic [10:0]           high_q;
	logic                  nonempty_q;
	logic                  out_valid_q;
	teb_out_t              out_q;

	logic [1:0]  op_s1;
	logic [10:0] aid_s1;
	logic [7:0]  bidx_s1;
	logic        hit_s1;

	logic          accept;
	logic          done;
	logic [7:0]    n1_cur;
	logic [9:0]    read_idx;
	logic          addr_ok;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic [7:0]    rd_data;
	logic [7:0]    octet;
	logic [7:0]    bit_mask;
	logic          add_ok;
	logic          we;
	logic [10:0]   low_d;
	logic [10:0]   high_d;
	logic          nonempty_d;
	logic [7:0]    n1_d;
	logic [7:0]    n2_d;
	logic [7:0]    len_d;
	logic [7:0]    elem_byte;
	logic          last_d;
	logic          in_field;

	teb_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// One item in flight: the next beat waits until the current one is written back.
	assign in_stall = (state_q == ST_EXEC);
	assign accept   = in_valid && !in_stall;
	assign done     = (state_q == ST_EXEC) && (!out_valid_q || !out_stall);

	// Octet address of the item: the AID's octet, or the bitmap octet being read.
	assign n1_cur   = nonempty_q ? (low_q[10:3] & 8'hFE) : 8'd0;
	assign read_idx = {2'd0, n1_cur} + {2'd0, in_data.byte_index} - 10'd3;

	always_comb begin
		if (in_data.op == OP_READ) begin
			addr_ok = (in_data.byte_index >= BYTE_FIRST_OCTET) &&
				(read_idx < 10'(NUM_OCTETS));
			rd_addr = addr_ok ? read_idx[AW-1:0] : '0;
		end else begin
			addr_ok = (in_data.aid <= 11'(MAX_AID));
			rd_addr = addr_ok ? in_data.aid[AW+2:3] : '0;
		end
	end

	teb_ram #(
		.WIDTH (8),
		.DEPTH (NUM_OCTETS),
		.AW    (AW)
	) u_bitmap (
		.clk   (clk),
		.we    (we),
		.waddr (wr_addr),
		.wdata (octet | bit_mask),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_EXEC;
				ST_EXEC: if (done) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Item captured at accept, alongside the memory read.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= in_data.op;
			aid_s1  <= in_data.aid;
			bidx_s1 <= in_data.byte_index;
			hit_s1  <= addr_ok && valid_q[rd_addr];
		end
	end

	// Modify: octet contents, AID range and the add write-back.
	assign octet    = hit_s1 ? rd_data : 8'd0;
	assign bit_mask = 8'h01 << aid_s1[2:0];
	assign add_ok   = (op_s1 == OP_ADD) && (aid_s1 <= 11'(MAX_AID));
	assign we       = done && add_ok;
	assign wr_addr  = aid_s1[AW+2:3];

	always_comb begin
		low_d      = low_q;
		high_d     = high_q;
		nonempty_d = nonempty_q;
		if (add_ok) begin
			nonempty_d = 1'b1;
			if (!nonempty_q) begin
				low_d  = aid_s1;
				high_d = aid_s1;
			end else begin
				if (aid_s1 < low_q) low_d = aid_s1;
				if (aid_s1 > high_q) high_d = aid_s1;
			end
		end else if (op_s1 == OP_CLEAR) begin
			nonempty_d = 1'b0;
			low_d      = 11'd0;
			high_d     = 11'd0;
		end
	end

	// Field length after this item's update.
	assign n1_d  = nonempty_d ? (low_d[10:3] & 8'hFE) : 8'd0;
	assign n2_d  = nonempty_d ? high_d[10:3] : 8'd0;
	assign len_d = n2_d - n1_d + 8'd4;

	// Information field byte for a read item.
	always_comb begin
		case (bidx_s1)
			BYTE_DTIM_COUNT:  elem_byte = cfg.dtim_count;
			BYTE_DTIM_PERIOD: elem_byte = cfg.dtim_period;
			BYTE_BMAP_CTRL:   elem_byte = n1_cur |
				{7'd0, cfg.multicast_pending && (cfg.dtim_count == 8'd0)};
			default:          elem_byte = octet;
		endcase
	end

	assign in_field = (op_s1 == OP_READ) && (bidx_s1 < len_d);
	assign last_d   = in_field && (bidx_s1 == len_d - 8'd1);

	// Set state write-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			low_q      <= 11'd0;
			high_q     <= 11'd0;
			nonempty_q <= 1'b0;
		end else if (done) begin
			low_q      <= low_d;
			high_q     <= high_d;
			nonempty_q <= nonempty_d;
			if (op_s1 == OP_CLEAR) begin
				valid_q <= '0;
			end else if (add_ok) begin
				valid_q[wr_addr] <= 1'b1;
			end
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (done) begin
			out_q.present      <= (op_s1 == OP_QUERY) && (aid_s1 <= 11'(MAX_AID)) &&
				((octet & bit_mask) != 8'd0);
			out_q.element_byte <= in_field ? elem_byte : 8'd0;
			out_q.last_byte    <= last_d;
			out_q.info_length  <= len_d;
			out_q.error        <= (op_s1 == OP_ADD) && !add_ok;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

>>> sv/teb_checker.sv
// Port-level checks of the TIM element builder, bound to the top level.
// Depends on teb_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module teb_checker
	import teb_pkg::*;
(
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     in_valid,
	input wire logic     in_stall,
	input wire logic     out_valid,
	input wire logic     out_stall,
	input wire teb_out_t out_data
);

	// A stalled result beat stays offered and unchanged.
	`TEB_ASSERT_IMP(a_out_hold, out_valid && out_stall, ##1 out_valid, "result beat dropped")
	`TEB_ASSERT_IMP(a_out_stable, out_valid && out_stall, ##1 $stable(out_data), "result beat changed")

	// One item at a time: the cycle after an accept the input is stalled.
	`TEB_ASSERT_IMP(a_one_item, in_valid && !in_stall, ##1 in_stall, "second item taken in flight")

	// With the output free at accept, the result shows once the execute state loads the output register.
	`TEB_ASSERT_IMP(a_latency, in_valid && !in_stall && !out_valid, ##2 out_valid, "result late")

endmodule

bind tim_element_builder_core teb_checker u_teb_checker (.*);

`default_nettype wire
